FILE: rtl/ffd_pkg.sv
// Shared types and constants for the free-fall detector.
// Depends on nothing; imported by ffd_div, free_fall_detector and the testbench.
package ffd_pkg;

    // Configuration register layout.
    localparam int unsigned REG_W = 15;
    localparam logic [REG_W-1:0] CENTER_RESET = 15'd4096;
    localparam logic [REG_W-1:0] TOL_RESET    = 15'd1638;

    // Register indexes on the configuration port.
    localparam logic CFG_CENTER = 1'b0;
    localparam logic CFG_TOL    = 1'b1;

    // Output limits.
    localparam logic [15:0] TIME_MAX     = 16'hFFFF;
    localparam logic [24:0] DIST_MAX     = 25'h1FFFFFF;
    localparam logic [31:0] DT_SAT_LIMIT = 32'd100000;

    // Distance division: numerator is 49*dt^2 with dt at most the limit above.
    // Dividing by 10000 is a shift by 4 and then two steps by 625 on 28-bit
    // chunks, each step a multiplication by a rounded-up reciprocal.
    localparam int unsigned NUM_W    = 39;
    localparam int unsigned QUOT_W   = 26;
    localparam int unsigned SCALE_SH = 4;
    localparam int unsigned CHUNK_W  = 28;
    localparam int unsigned RECIP_W  = 29;
    localparam int unsigned RECIP_SH = 38;
    localparam logic [RECIP_W-1:0] RECIP_625 = 29'd439804652;
    localparam logic [9:0]         DIV_625   = 10'd625;

    // Shared squarer operand and product widths.
    localparam int unsigned OP_W   = 17;
    localparam int unsigned PROD_W = 2 * OP_W;

    // One input request: timestamped three-axis sample, Q4.12 g.
    typedef struct packed {
        logic        [31:0] timestamp_ms;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } t_in;

    // One result request: fall duration and fall distance.
    typedef struct packed {
        logic [15:0] fall_time_ms;
        logic [24:0] fall_distance_mm;
    } t_out;

endpackage

FILE: rtl/ffd_div.sv
// Divider by the constant 10000 using reciprocal multiplication on two chunks.
// Depends on ffd_pkg for widths and the reciprocal constants.
module ffd_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ffd_pkg::NUM_W-1:0]   i_num,
    output logic                        o_done,
    output logic [ffd_pkg::QUOT_W-1:0]  o_quot
);
    import ffd_pkg::*;

    localparam int unsigned RPROD_W = CHUNK_W + RECIP_W;
    localparam int unsigned CQ_W    = RPROD_W - RECIP_SH;
    localparam int unsigned LOW_W   = 18;
    localparam int unsigned HIGH_W  = NUM_W - SCALE_SH - LOW_W;
    localparam int unsigned Q1_W    = QUOT_W - LOW_W;
    localparam int unsigned REM_W   = CHUNK_W - LOW_W;

    typedef enum logic [1:0] {
        D_IDLE, D_HIGH, D_REM, D_LOW
    } t_dstate;

    t_dstate             r_state;
    logic                r_done;
    logic [CHUNK_W-1:0]  r_chunk;
    logic [LOW_W-1:0]    r_low;
    logic [Q1_W-1:0]     r_q1;
    logic [QUOT_W-1:0]   r_quot;

    logic [RPROD_W-1:0]  rprod;
    logic [CQ_W-1:0]     chunk_q;
    logic [HIGH_W-1:0]   q1_mul;
    logic [HIGH_W-1:0]   rem;

    // Quotient of the current chunk by 625; exact for every 28-bit chunk.
    assign rprod   = RPROD_W'(r_chunk) * RPROD_W'(RECIP_625);
    assign chunk_q = rprod[RPROD_W-1:RECIP_SH];

    // Remainder of the high chunk, always below 625.
    assign q1_mul = HIGH_W'(r_q1) * HIGH_W'(DIV_625);
    assign rem    = r_chunk[HIGH_W-1:0] - q1_mul;

    // The numerator is shifted down by 4 (the factor 16 of 10000). The high
    // 17 bits are divided first; their remainder joined with the low 18 bits
    // forms the second chunk, whose quotient gives the low quotient bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= !i_start && (r_state == D_LOW);
            if (i_start) begin
                r_chunk <= CHUNK_W'(i_num[NUM_W-1:NUM_W-HIGH_W]);
                r_low   <= i_num[NUM_W-HIGH_W-1:SCALE_SH];
                r_state <= D_HIGH;
            end else begin
                case (r_state)
                    D_HIGH: begin
                        r_q1    <= chunk_q[Q1_W-1:0];
                        r_state <= D_REM;
                    end
                    D_REM: begin
                        r_chunk <= {rem[REM_W-1:0], r_low};
                        r_state <= D_LOW;
                    end
                    D_LOW: begin
                        r_quot  <= {r_q1, chunk_q[LOW_W-1:0]};
                        r_state <= D_IDLE;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: rtl/free_fall_detector.sv
// Free-fall detector: a sample request is accepted in idle and the next one only after
// six squarer steps, one decision and the return to idle.
// The sample that ends a fall then takes a squaring, a scale by 49 and a reciprocal
// divide by 10000 before it shows its result and the next request is taken; over
// 100000 ms the distance is skipped. Stalls on the result channel add to this.
// Synchronous active-low reset: waiting phase, start time zero, registers at defaults.
module free_fall_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [ffd_pkg::REG_W-1:0]     i_cfg_data,
    // Sample channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ffd_pkg::t_in                  i_in,
    // Result channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ffd_pkg::t_out                 o_out
);
    import ffd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SQ, S_DECIDE, S_DT2, S_MUL49, S_DIVST, S_DIV, S_OUT
    } t_state;

    t_state              r_state;
    logic [2:0]          r_step;
    logic                r_phase;
    logic [31:0]         r_start;
    logic [REG_W-1:0]    r_center;
    logic [REG_W-1:0]    r_tol;

    logic [31:0]         r_ts;
    logic [15:0]         r_ax;
    logic [15:0]         r_ay;
    logic [15:0]         r_az;
    logic [PROD_W-1:0]   r_prod;
    logic [31:0]         r_mag;
    logic [29:0]         r_lo2;
    logic [31:0]         r_hi2;
    logic [31:0]         r_dt;
    logic [NUM_W-1:0]    r_num;
    logic [24:0]         r_dist;
    logic                r_out_valid;
    t_out                r_out;

    logic [15:0]         lo_diff;
    logic [15:0]         hi_sum;
    logic [OP_W-1:0]     op;
    logic [PROD_W-1:0]   square;
    logic                rest;
    logic [31:0]         dt_now;
    logic                div_done;
    logic [QUOT_W-1:0]   div_quot;
    logic                out_free;

    // Rest window bounds from the configuration registers.
    assign lo_diff = {1'b0, r_center} - {1'b0, r_tol};
    assign hi_sum  = {1'b0, r_center} + {1'b0, r_tol};

    // Operand of the shared squarer, chosen by the sequencer.
    always_comb begin
        op = '0;
        if (r_state == S_SQ) begin
            case (r_step)
                3'd0:    op = {1'b0, r_ax};
                3'd1:    op = {1'b0, r_ay};
                3'd2:    op = {1'b0, r_az};
                3'd3:    op = {2'b0, lo_diff[14:0]};
                3'd4:    op = {1'b0, hi_sum};
                default: op = '0;
            endcase
        end else if (r_state == S_DT2) begin
            op = r_dt[OP_W-1:0];
        end
    end

    assign square = op * op;

    // Rest test on squared magnitude; a negative lower bound passes every magnitude on the low side.
    assign rest   = (lo_diff[15] || (r_mag > {2'b0, r_lo2})) && (r_mag < r_hi2);
    assign dt_now = r_ts - r_start;

    // The result register can take a new result when empty or being drained.
    assign out_free = !r_out_valid || !i_out_stall;

    ffd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIVST),
        .i_num   (r_num),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= CENTER_RESET;
            r_tol    <= TOL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER: r_center <= i_cfg_data;
                CFG_TOL:    r_tol    <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Sequencer with the detector state and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_phase     <= 1'b0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ts    <= i_in.timestamp_ms;
                        r_ax    <= i_in.accel_x[15] ? 16'(-i_in.accel_x) : i_in.accel_x;
                        r_ay    <= i_in.accel_y[15] ? 16'(-i_in.accel_y) : i_in.accel_y;
                        r_az    <= i_in.accel_z[15] ? 16'(-i_in.accel_z) : i_in.accel_z;
                        r_mag   <= '0;
                        r_step  <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    // Square this step's operand; fold in the previous product.
                    r_prod <= square;
                    case (r_step)
                        3'd1, 3'd2, 3'd3: r_mag <= r_mag + r_prod[31:0];
                        3'd4:             r_lo2 <= r_prod[29:0];
                        3'd5:             r_hi2 <= r_prod[31:0];
                        default:          ;
                    endcase
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd5) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_state <= S_IDLE;
                    if (!r_phase) begin
                        if (!rest) begin
                            r_phase <= 1'b1;
                            r_start <= r_ts;
                        end
                    end else if (rest) begin
                        r_phase <= 1'b0;
                        r_dt    <= dt_now;
                        if (dt_now > DT_SAT_LIMIT) begin
                            r_dist  <= DIST_MAX;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_DT2;
                        end
                    end
                end
                S_DT2: begin
                    r_prod  <= square;
                    r_state <= S_MUL49;
                end
                S_MUL49: begin
                    // Times 49 as 32 + 16 + 1.
                    r_num   <= ({5'b0, r_prod} << 5) + ({5'b0, r_prod} << 4)
                               + {5'b0, r_prod};
                    r_state <= S_DIVST;
                end
                S_DIVST: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_dist  <= div_quot[QUOT_W-1] ? DIST_MAX : div_quot[24:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out.fall_time_ms     <= (r_dt > {16'b0, TIME_MAX}) ?
                                                  TIME_MAX : r_dt[15:0];
                        r_out.fall_distance_mm <= r_dist;
                        r_out_valid            <= 1'b1;
                        r_state                <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // The divider finishes only while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider done outside its wait state");

    // A result is only produced after the fall has been closed.
    a_out_rearmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> !r_phase)
        else $error("result pending while still falling");

    // An unsaturated fall time can never give a saturated distance.
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.fall_time_ms != TIME_MAX)) |->
        (o_out.fall_distance_mm != DIST_MAX))
        else $error("distance saturated for a short fall");

    // The squaring sequence never runs past its last step.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ) |-> (r_step <= 3'd5))
        else $error("squaring step out of range");
`endif

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the free-fall detector.
// Drives sample requests and register writes, predicts each fall result and checks it.
// Depends on rtl/ffd_pkg.sv and rtl/free_fall_detector.sv.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ffd_pkg::*;

    localparam int unsigned DRAIN_CYCLES    = 48;
    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned ITEMS_PER_PHASE = 115;
    localparam int unsigned NUM_SETTINGS    = 8;

    // Clock, reset and block connections.
    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              cfg_we   = 1'b0;
    logic              cfg_idx  = CFG_CENTER;
    logic [REG_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    t_in               in_req   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out              out_rsp;

    // Predictor state: its own copy of the registers, the phase and the start time.
    logic [REG_W-1:0]  ctr_g = CENTER_RESET;
    logic [REG_W-1:0]  tol_g = TOL_RESET;
    bit                falling = 1'b0;
    logic [31:0]       fall_start = '0;

    // Pending sample requests and expected fall reports.
    t_in               sample_q[$];
    t_out              fall_q[$];
    int unsigned       n_queued = 0;
    int unsigned       n_sent = 0;
    int unsigned       gap_left = 0;
    int unsigned       stall_left = 0;
    int unsigned       quiet_cycles = 0;
    bit                idle_on = 1'b1;
    int                errors = 0;
    logic [31:0]       ts_now = 32'd700000;

    free_fall_detector i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_rsp)
    );

    always #5 i_clk = ~i_clk;

    // Updates the phase for one accepted sample and queues the fall report it ends.
    function automatic void predict_landing(input t_in s);
        longint          ax, ay, az, mag2, lo, hi;
        bit              rest;
        logic [31:0]     dt;
        logic [63:0]     dist_full;
        t_out            r;
        ax = longint'($signed(s.accel_x));
        ay = longint'($signed(s.accel_y));
        az = longint'($signed(s.accel_z));
        mag2 = ax * ax + ay * ay + az * az;
        lo = longint'(ctr_g) - longint'(tol_g);
        hi = longint'(ctr_g) + longint'(tol_g);
        // A negative lower bound lets every magnitude pass on that side.
        rest = (lo < 0 || mag2 > lo * lo) && mag2 < hi * hi;
        if (!falling) begin
            if (!rest) begin
                falling = 1'b1;
                fall_start = s.timestamp_ms;
            end
        end else if (rest) begin
            // Time wraps modulo 2^32, so a backwards landing saturates both fields.
            dt = s.timestamp_ms - fall_start;
            r.fall_time_ms = (dt > 32'(TIME_MAX)) ? TIME_MAX : dt[15:0];
            if (dt > DT_SAT_LIMIT) begin
                r.fall_distance_mm = DIST_MAX;
            end else begin
                dist_full = (64'(dt) * 64'(dt) * 64'd49) / 64'd10000;
                r.fall_distance_mm = (dist_full > 64'(DIST_MAX)) ? DIST_MAX
                                                                 : dist_full[24:0];
            end
            fall_q.push_back(r);
            falling = 1'b0;
        end
    endfunction

    function automatic t_in sample_of(input logic [31:0] t, input int x, input int y,
                                      input int z);
        t_in s;
        s.timestamp_ms = t;
        s.accel_x = 16'(x);
        s.accel_y = 16'(y);
        s.accel_z = 16'(z);
        return s;
    endfunction

    // Uniform value in [-a, a].
    function automatic int srand(input int a);
        return int'($urandom_range(0, 2 * a)) - a;
    endfunction

    // Mostly small forward steps, sometimes long jumps and steps backwards.
    function automatic logic [31:0] next_ts();
        int unsigned r;
        r = $urandom_range(0, 63);
        if (r < 2)
            ts_now = ts_now - $urandom_range(1, 2000);
        else if (r < 6)
            ts_now = ts_now + $urandom_range(60000, 120000);
        else
            ts_now = ts_now + $urandom_range(1, 400);
        return ts_now;
    endfunction

    // A sample whose magnitude aims inside the rest window of the current setting.
    function automatic t_in rest_sample(input logic [31:0] t);
        int m;
        int axis;
        int v[3];
        if (tol_g == 0)
            return sample_of(t, int'($urandom), int'($urandom), int'($urandom));
        m = int'(ctr_g) + srand(int'(tol_g) - 1);
        if (m < 0) m = 0;
        if (m > 32767) m = 32767;
        v[0] = srand(16);
        v[1] = srand(16);
        v[2] = srand(16);
        axis = $urandom_range(0, 2);
        v[axis] = $urandom_range(0, 1) ? m : -m;
        return sample_of(t, v[0], v[1], v[2]);
    endfunction

    // A sample whose magnitude aims below or above the rest window.
    function automatic t_in fall_sample(input logic [31:0] t);
        int a;
        int hi;
        int axis;
        int v[3];
        hi = int'(ctr_g) + int'(tol_g);
        if (ctr_g > tol_g && $urandom_range(0, 1) == 1) begin
            a = (int'(ctr_g) - int'(tol_g)) / 2;
            return sample_of(t, srand(a), srand(a), srand(a));
        end
        if (hi < 32767) begin
            v[0] = srand(64);
            v[1] = srand(64);
            v[2] = srand(64);
            axis = $urandom_range(0, 2);
            v[axis] = int'($urandom_range(hi, 32767));
            if ($urandom_range(0, 1) == 1) v[axis] = -v[axis];
        end else begin
            foreach (v[i]) begin
                v[i] = int'($urandom_range(24000, 32767));
                if ($urandom_range(0, 1) == 1) v[i] = -v[i];
            end
        end
        return sample_of(t, v[0], v[1], v[2]);
    endfunction

    task automatic push_sample(input t_in s);
        sample_q.push_back(s);
        n_queued++;
    endtask

    // Mostly whole falls (rest, fall, landing) with random content, plus noise
    // and falls that never land.
    task automatic queue_random(input int unsigned count);
        int unsigned done_cnt;
        int unsigned n_rest;
        int unsigned n_fall;
        done_cnt = 0;
        while (done_cnt < count) begin
            case ($urandom_range(0, 9))
                8: begin
                    push_sample(sample_of($urandom, int'($urandom), int'($urandom),
                                          int'($urandom)));
                    done_cnt++;
                end
                9: begin
                    n_fall = $urandom_range(1, 4);
                    repeat (n_fall) push_sample(fall_sample(next_ts()));
                    done_cnt += n_fall;
                end
                default: begin
                    n_rest = $urandom_range(0, 3);
                    n_fall = $urandom_range(1, 6);
                    repeat (n_rest) push_sample(rest_sample(next_ts()));
                    repeat (n_fall) push_sample(fall_sample(next_ts()));
                    push_sample(rest_sample(next_ts()));
                    done_cnt += n_rest + n_fall + 1;
                end
            endcase
        end
    endtask

    task automatic write_reg(input logic idx, input logic [REG_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_CENTER)
            ctr_g = val;
        else
            tol_g = val;
    endtask

    // Holds the sender until every request is sent and every report is back,
    // then lets a sample that reports nothing finish inside the block.
    task automatic wait_drain();
        while (n_sent != n_queued || fall_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Sample driver: presents queued requests with a random gap after each one while idling is on.
    always @(posedge i_clk) begin : sample_driver
        logic        nxt_valid;
        int unsigned nxt_gap;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            nxt_valid = in_valid;
            nxt_gap = gap_left;
            if (in_valid && !in_stall) begin
                predict_landing(in_req);
                n_sent++;
                nxt_valid = 1'b0;
                nxt_gap = idle_on ? $urandom_range(0, 3) : 0;
            end
            if (!nxt_valid) begin
                if (nxt_gap > 0) begin
                    nxt_gap--;
                end else if (sample_q.size() > 0) begin
                    in_req <= sample_q.pop_front();
                    nxt_valid = 1'b1;
                end
            end
            in_valid <= nxt_valid;
            gap_left <= nxt_gap;
        end
    end

    // Result monitor: checks each report and, while idling is on, stalls the next one a random while.
    always @(posedge i_clk) begin : result_monitor
        t_out        want;
        int unsigned n;
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (out_valid && !out_stall) begin
            if (fall_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected report, expected none, got time %0d distance %0d",
                         $time, out_rsp.fall_time_ms, out_rsp.fall_distance_mm);
            end else begin
                want = fall_q.pop_front();
                if (out_rsp.fall_time_ms !== want.fall_time_ms) begin
                    errors++;
                    $display("%0t: fall_time_ms expected %0d, got %0d",
                             $time, want.fall_time_ms, out_rsp.fall_time_ms);
                end
                if (out_rsp.fall_distance_mm !== want.fall_distance_mm) begin
                    errors++;
                    $display("%0t: fall_distance_mm expected %0d, got %0d",
                             $time, want.fall_distance_mm, out_rsp.fall_distance_mm);
                end
            end
            n = idle_on ? $urandom_range(0, 3) : 0;
            stall_left <= n;
            out_stall  <= (n != 0);
        end else if (out_valid) begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left > 1);
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Register settings for the random phases, the extremes among them.
    logic [REG_W-1:0] ctr_set [NUM_SETTINGS] = '{15'd4096, 15'd0, 15'd32767, 15'd100,
                                                 15'd4096, 15'd32767, 15'd20000, 15'd0};
    logic [REG_W-1:0] tol_set [NUM_SETTINGS] = '{15'd1638, 15'd0, 15'd32767, 15'd5000,
                                                 15'd0, 15'd0, 15'd3000, 15'd32767};

    initial begin : stimulus
        int p;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed falls at the reset setting: window edges, saturation points,
        // wrap of the timestamp and extreme axis values.
        push_sample(sample_of(32'd0, 0, 0, 4096));
        push_sample(sample_of(32'hFFFF_FFFF, -32768, -32768, -32768));
        push_sample(sample_of(32'd5, 0, 0, 4096));
        push_sample(sample_of(32'd1000, 32767, 0, 0));
        push_sample(sample_of(32'd66535, 0, 0, 5733));
        push_sample(sample_of(32'd70000, 0, 0, 5734));
        push_sample(sample_of(32'd135536, 0, 0, 2459));
        push_sample(sample_of(32'd140000, 0, 0, 2458));
        push_sample(sample_of(32'd222750, 0, 4096, 0));
        push_sample(sample_of(32'd230000, 0, 0, 0));
        push_sample(sample_of(32'd312760, 0, 0, -4096));
        push_sample(sample_of(32'd400000, 0, 0, 0));
        push_sample(sample_of(32'd500001, 4096, 0, 0));
        push_sample(sample_of(32'd600000, 100, -100, 0));
        push_sample(sample_of(32'd599000, -4096, 0, 0));
        push_sample(sample_of(32'd600100, 2365, 2365, 2365));
        // Leave a fall open so the next setting lands it.
        push_sample(sample_of(32'd600200, 0, -32768, 0));
        wait_drain();

        // One phase per setting, the last one drawn at random; one phase without idling.
        for (p = 0; p <= NUM_SETTINGS; p++) begin
            if (p < NUM_SETTINGS) begin
                write_reg(CFG_CENTER, ctr_set[p]);
                write_reg(CFG_TOL, tol_set[p]);
            end else begin
                write_reg(CFG_CENTER, REG_W'($urandom_range(0, 32767)));
                write_reg(CFG_TOL, REG_W'($urandom_range(0, 8000)));
            end
            idle_on = (p != 2);
            queue_random(ITEMS_PER_PHASE);
            wait_drain();
        end

        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
